>>> rtl/cmec_pkg.sv
// ----------------------------------------------------------------------------
// cmec_pkg
// Shared constants and types for the closed mesh edge check block.
// ----------------------------------------------------------------------------
package cmec_pkg;

    // Edge table geometry
    localparam int SLOTS = 4096;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = IW + 1;

    // Hash constants
    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam logic [63:0] MIX_MUL    = 64'hbf58476d1ce4e5b9;
    localparam int          MIX_SHIFT1 = 29;
    localparam int          MIX_SHIFT2 = 32;

    // Sequencer last step indices
    localparam logic [2:0] HASH_LAST = 3'd5;
    localparam logic [2:0] MIX_LAST  = 3'd5;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    typedef struct packed {
        t_point a;
        t_point b;
        t_point c;
        logic   last;
    } t_tri;

    typedef struct packed {
        logic [63:0] lo_xy;
        logic [31:0] lo_zz;
        logic [63:0] hi_xy;
        logic [31:0] hi_zz;
        logic        fwd;
        logic        bwd;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic edge_start;
        logic hash;
        logic mix;
        logic read;
        logic check;
        logic report;
        logic clear;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic failed;
        logic degen;
        logic step_end;
        logic used;
        logic match;
        logic probe_end;
        logic side_end;
        logic last_tri;
        logic clr_end;
        logic out_free;
    } t_status;

endpackage

>>> rtl/cmec_tri_if.sv
// ----------------------------------------------------------------------------
// cmec_tri_if
// Triangle request channel: valid/ready handshake with nine corner words.
// ----------------------------------------------------------------------------
interface cmec_tri_if;
    logic        valid;
    logic        ready;
    logic [31:0] corner_a_x;
    logic [31:0] corner_a_y;
    logic [31:0] corner_a_z;
    logic [31:0] corner_b_x;
    logic [31:0] corner_b_y;
    logic [31:0] corner_b_z;
    logic [31:0] corner_c_x;
    logic [31:0] corner_c_y;
    logic [31:0] corner_c_z;
    logic        last_triangle;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
               corner_b_z, corner_c_x, corner_c_y, corner_c_z, last_triangle,
        output ready
    );
endinterface

>>> rtl/cmec_res_if.sv
// ----------------------------------------------------------------------------
// cmec_res_if
// Result channel: valid/ready handshake with the mesh verdict.
// ----------------------------------------------------------------------------
interface cmec_res_if;
    logic valid;
    logic ready;
    logic mesh_closed;
    logic check_status;

    modport source (output valid, mesh_closed, check_status, input ready);
    modport sink   (input valid, mesh_closed, check_status, output ready);
endinterface

>>> rtl/closed_mesh_edge_check_top.sv
// ----------------------------------------------------------------------------
// closed_mesh_edge_check_top
// Checks that a triangle mesh is closed and consistently oriented.
// ----------------------------------------------------------------------------
// Triangles arrive one per request; one result follows each triangle marked
// last. A triangle is accepted, then each edge gets a setup step, the hash
// steps, the mix steps and one table probe (read, then compare and write)
// when it lands on its first probe, then a wrap-up step ends the triangle.
// Each further occupied slot in a probe chain adds another probe, up to
// 4096 probes per edge on a full table. A degenerate edge or an already
// failed mesh skips the remaining edges of the triangle. The hash and mix
// run one step a cycle to keep each multiply narrow, and the edge table has
// a single read/write port. A last triangle then holds until the result
// register is free. After reset and after every last triangle the used-bit
// memory is swept, one slot a cycle, during which no triangle is taken.
module closed_mesh_edge_check_top
    import cmec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmec_tri_if.sink   i_tri,
    cmec_res_if.source o_res
);

    t_cmd    w_cmd;
    t_status w_status;
    t_tri    w_tri;

    assign w_tri.a    = '{i_tri.corner_a_x, i_tri.corner_a_y, i_tri.corner_a_z};
    assign w_tri.b    = '{i_tri.corner_b_x, i_tri.corner_b_y, i_tri.corner_b_z};
    assign w_tri.c    = '{i_tri.corner_c_x, i_tri.corner_c_y, i_tri.corner_c_z};
    assign w_tri.last = i_tri.last_triangle;

    cmec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri_valid (i_tri.valid),
        .i_status    (w_status),
        .o_tri_ready (i_tri.ready),
        .o_cmd       (w_cmd)
    );

    cmec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_tri          (w_tri),
        .i_out_ready    (o_res.ready),
        .o_status       (w_status),
        .o_out_valid    (o_res.valid),
        .o_mesh_closed  (o_res.mesh_closed),
        .o_check_status (o_res.check_status)
    );

endmodule

>>> rtl/cmec_ctrl.sv
// ----------------------------------------------------------------------------
// cmec_ctrl
// Sequencer for the edge check: clear sweep, per-edge hash and table probe.
// ----------------------------------------------------------------------------
module cmec_ctrl
    import cmec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_tri_valid,
    input  t_status i_status,
    output logic    o_tri_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_EDGE   = 9'b000000100,
        S_HASH   = 9'b000001000,
        S_MIX    = 9'b000010000,
        S_READ   = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_REPORT = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_tri_valid) n_state = S_EDGE;
            end
            S_EDGE: begin
                if (i_status.failed || i_status.degen) n_state = S_DONE;
                else n_state = S_HASH;
            end
            S_HASH: begin
                if (i_status.step_end) n_state = S_MIX;
            end
            S_MIX: begin
                if (i_status.step_end) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.used || i_status.match || i_status.probe_end) begin
                    n_state = i_status.side_end ? S_DONE : S_EDGE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_state = i_status.last_tri ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                if (i_status.out_free) n_state = S_CLEAR;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Commands
    assign o_tri_ready      = (r_state == S_IDLE);
    assign o_cmd.load       = (r_state == S_IDLE) && i_tri_valid;
    assign o_cmd.edge_start = (r_state == S_EDGE);
    assign o_cmd.hash       = (r_state == S_HASH);
    assign o_cmd.mix        = (r_state == S_MIX);
    assign o_cmd.read       = (r_state == S_READ);
    assign o_cmd.check      = (r_state == S_CHECK);
    assign o_cmd.report     = (r_state == S_REPORT) && i_status.out_free;
    assign o_cmd.clear      = (r_state == S_CLEAR);

endmodule

>>> rtl/cmec_dp.sv
// ----------------------------------------------------------------------------
// cmec_dp
// Datapath: triangle registers, edge ordering, hash unit, edge table and
// result register.
// ----------------------------------------------------------------------------
module cmec_dp
    import cmec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_tri    i_tri,
    input  logic    i_out_ready,
    output t_status o_status,
    output logic    o_out_valid,
    output logic    o_mesh_closed,
    output logic    o_check_status
);

    function automatic logic [31:0] norm_zero(input logic [31:0] v);
        return (v == 32'h80000000) ? 32'h0 : v;
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] v);
        return v[31] ? ~v : (v | 32'h80000000);
    endfunction

    function automatic logic point_before(input t_point p, input t_point q);
        logic r;
        if (p.x != q.x) r = order_key(p.x) < order_key(q.x);
        else if (p.y != q.y) r = order_key(p.y) < order_key(q.y);
        else r = order_key(p.z) < order_key(q.z);
        return r;
    endfunction

    // Triangle and edge registers
    t_point      r_corner_a, r_corner_b, r_corner_c;
    logic        r_last;
    logic [1:0]  r_side;
    t_point      r_lo, r_hi;
    logic        r_fwd;

    // Hash unit registers
    logic [63:0] r_hash;
    logic [2:0]  r_step;
    logic [63:0] r_prod;
    logic [31:0] r_cross1, r_cross2;

    // Probe and mesh state
    logic [IW-1:0] r_addr;
    logic [IW-1:0] r_probe_n;
    logic [IW-1:0] r_clr_addr;
    logic [CW-1:0] r_open;
    logic          r_failed;
    logic          r_ovf;

    // Table storage
    t_slot mem_slot [SLOTS];
    logic  mem_used [SLOTS];
    t_slot r_rd_slot;
    logic  r_rd_used;

    // Result register
    logic r_out_valid, r_out_closed, r_out_status;

    // Edge select
    t_point w_from, w_to;
    always_comb begin
        case (r_side)
            2'd0:    begin w_from = r_corner_a; w_to = r_corner_b; end
            2'd1:    begin w_from = r_corner_b; w_to = r_corner_c; end
            default: begin w_from = r_corner_c; w_to = r_corner_a; end
        endcase
    end

    logic w_degen, w_fwd;
    assign w_degen = (w_from == w_to);
    assign w_fwd   = point_before(w_from, w_to);

    // FNV-1a step
    logic [31:0] w_word;
    logic [63:0] w_fnv_x, w_fnv_next;
    always_comb begin
        case (r_step)
            3'd0:    w_word = r_lo.x;
            3'd1:    w_word = r_lo.y;
            3'd2:    w_word = r_lo.z;
            3'd3:    w_word = r_hi.x;
            3'd4:    w_word = r_hi.y;
            default: w_word = r_hi.z;
        endcase
    end
    assign w_fnv_x    = r_hash ^ {32'h0, w_word};
    assign w_fnv_next = (w_fnv_x << 40) + (w_fnv_x * {55'h0, FNV_PRIME[8:0]});

    // Final mix partial products
    logic [63:0] w_m_ll, w_m_lh, w_m_hl, w_fin;
    assign w_m_ll = {32'h0, r_hash[31:0]} * {32'h0, MIX_MUL[31:0]};
    assign w_m_lh = {32'h0, r_hash[31:0]} * {32'h0, MIX_MUL[63:32]};
    assign w_m_hl = {32'h0, r_hash[63:32]} * {32'h0, MIX_MUL[31:0]};
    assign w_fin  = r_hash ^ (r_hash >> MIX_SHIFT2);

    // Slot compare
    logic [63:0] w_lxy, w_hxy;
    logic        w_match, w_seen;
    assign w_lxy   = {r_lo.x, r_lo.y};
    assign w_hxy   = {r_hi.x, r_hi.y};
    assign w_match = (r_rd_slot.lo_xy == w_lxy) && (r_rd_slot.lo_zz == r_lo.z) &&
                     (r_rd_slot.hi_xy == w_hxy) && (r_rd_slot.hi_zz == r_hi.z);
    assign w_seen  = r_fwd ? r_rd_slot.fwd : r_rd_slot.bwd;

    // Table write data
    logic  w_slot_we;
    t_slot w_slot_wd;
    always_comb begin
        w_slot_we = 1'b0;
        w_slot_wd = r_rd_slot;
        if (i_cmd.check && !r_rd_used) begin
            w_slot_we = 1'b1;
            w_slot_wd = '{lo_xy: w_lxy, lo_zz: r_lo.z, hi_xy: w_hxy, hi_zz: r_hi.z,
                          fwd: r_fwd, bwd: !r_fwd};
        end else if (i_cmd.check && w_match && !w_seen) begin
            w_slot_we = 1'b1;
            if (r_fwd) w_slot_wd.fwd = 1'b1;
            else w_slot_wd.bwd = 1'b1;
        end
    end

    // Slot payload memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) mem_slot[r_addr] <= w_slot_wd;
        if (i_cmd.read) r_rd_slot <= mem_slot[r_addr];
    end

    // Used-bit memory, cleared by sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) mem_used[r_clr_addr] <= 1'b0;
        else if (i_cmd.check && !r_rd_used) mem_used[r_addr] <= 1'b1;
        if (i_cmd.read) r_rd_used <= mem_used[r_addr];
    end

    // Triangle, edge and hash payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_corner_a <= '{norm_zero(i_tri.a.x), norm_zero(i_tri.a.y), norm_zero(i_tri.a.z)};
            r_corner_b <= '{norm_zero(i_tri.b.x), norm_zero(i_tri.b.y), norm_zero(i_tri.b.z)};
            r_corner_c <= '{norm_zero(i_tri.c.x), norm_zero(i_tri.c.y), norm_zero(i_tri.c.z)};
            r_last     <= i_tri.last;
        end
        if (i_cmd.edge_start) begin
            r_fwd  <= w_fwd;
            r_lo   <= w_fwd ? w_from : w_to;
            r_hi   <= w_fwd ? w_to : w_from;
            r_hash <= FNV_OFFSET;
            r_step <= 3'd0;
        end
        if (i_cmd.hash) begin
            r_hash <= w_fnv_next;
            r_step <= (r_step == HASH_LAST) ? 3'd0 : r_step + 3'd1;
        end
        if (i_cmd.mix) begin
            r_step <= r_step + 3'd1;
            case (r_step)
                3'd0:    r_hash   <= r_hash ^ (r_hash >> MIX_SHIFT1);
                3'd1:    r_prod   <= w_m_ll;
                3'd2:    r_cross1 <= w_m_lh[31:0];
                3'd3:    r_cross2 <= w_m_hl[31:0];
                3'd4:    r_hash   <= r_prod + {r_cross1 + r_cross2, 32'h0};
                default: begin
                    r_hash    <= w_fin;
                    r_addr    <= w_fin[IW-1:0];
                    r_probe_n <= '0;
                end
            endcase
        end
        if (i_cmd.check && r_rd_used && !w_match && r_probe_n != IW'(SLOTS - 1)) begin
            r_addr    <= r_addr + IW'(1);
            r_probe_n <= r_probe_n + IW'(1);
        end
    end

    // Control state: side, clear sweep, mesh flags, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side       <= 2'd0;
            r_clr_addr   <= '0;
            r_open       <= '0;
            r_failed     <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_closed <= 1'b0;
            r_out_status <= 1'b0;
        end else begin
            if (i_cmd.load) r_side <= 2'd0;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + IW'(1);
            if (i_cmd.edge_start && !r_failed && w_degen) r_failed <= 1'b1;
            if (i_cmd.check) begin
                if (!r_rd_used) begin
                    r_open <= r_open + CW'(1);
                    r_side <= r_side + 2'd1;
                end else if (w_match) begin
                    if (w_seen) r_failed <= 1'b1;
                    else if (r_open != '0) r_open <= r_open - CW'(1);
                    r_side <= r_side + 2'd1;
                end else if (r_probe_n == IW'(SLOTS - 1)) begin
                    r_ovf  <= 1'b1;
                    r_side <= r_side + 2'd1;
                end
            end
            // Hold result until taken; drop flags for the next mesh
            if (i_cmd.report) begin
                r_out_valid  <= 1'b1;
                r_out_closed <= !r_failed && !r_ovf && (r_open == '0);
                r_out_status <= r_ovf;
                r_open       <= '0;
                r_failed     <= 1'b0;
                r_ovf        <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.failed    = r_failed;
    assign o_status.degen     = w_degen;
    assign o_status.step_end  = (r_step == (i_cmd.mix ? MIX_LAST : HASH_LAST));
    assign o_status.used      = r_rd_used;
    assign o_status.match     = w_match;
    assign o_status.probe_end = (r_probe_n == IW'(SLOTS - 1));
    assign o_status.side_end  = (r_side == 2'd2);
    assign o_status.last_tri  = r_last;
    assign o_status.clr_end   = (r_clr_addr == IW'(SLOTS - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_mesh_closed  = r_out_closed;
    assign o_check_status = r_out_status;

endmodule
